// ===== design/rgb_to_yuv420_converter_defines.svh =====
// Assertion macros for the RGB to YUV 4:2:0 converter.
// Included by the top level; no other dependencies.
`ifndef RGB_TO_YUV420_CONVERTER_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define RYC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("ryc: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define RYC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ryc: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define RYC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ryc: implication failed");

`endif

// ===== design/ryc_pkg.sv =====
// Shared types, constants and helpers of the RGB to YUV 4:2:0 converter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package ryc_pkg;

	// Field and register widths
	localparam int PIX_W  = 8;
	localparam int CFG_W  = 9;
	localparam int PAIR_W = PIX_W + 1;   // sum of two pixels
	localparam int SUM_W  = PIX_W + 2;   // sum of four pixels
	localparam int LINE_W = 3 * PAIR_W;  // one stored pair sum, r/g/b
	localparam int PIXEL_W = 3 * PIX_W;
	localparam int CFG_IDX_W = 1;

	// Size defaults
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int SIZE_RESET     = 256;

	// Luma coefficients, Q16
	localparam int COEF_Y_R = 16839;
	localparam int COEF_Y_G = 33059;
	localparam int COEF_Y_B = 6420;
	localparam int LUMA_BIAS  = (1 << 15) + (16 << 16);
	localparam int LUMA_SHIFT = 16;
	localparam int LPROD_W = 24;
	localparam int LSUM_W  = 25;

	// Chroma coefficients, Q16 applied to four-pixel sums (hence >> 18)
	localparam int COEF_U_R = 9719;    // subtracted
	localparam int COEF_U_G = 19081;   // subtracted
	localparam int COEF_U_B = 28800;
	localparam int COEF_V_R = 28800;
	localparam int COEF_V_G = 24116;   // subtracted
	localparam int COEF_V_B = 4684;    // subtracted
	localparam int UV_BIAS  = 257 << 17;
	localparam int UV_SHIFT = 18;
	localparam int CPROD_W  = 25;
	localparam int ACC_W    = 28;
	localparam int PIX_MAX  = 'hff;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic [PAIR_W-1:0] red;
		logic [PAIR_W-1:0] green;
		logic [PAIR_W-1:0] blue;
	} pair_sum_t;

	// Round-down, then clamp to 0..255
	function automatic logic [PIX_W-1:0] clip_uv(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] t;
		logic [PIX_W-1:0] res;
		t = acc >>> UV_SHIFT;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (t > ACC_W'(PIX_MAX)) begin
			res = PIX_W'(PIX_MAX);
		end else begin
			res = t[PIX_W-1:0];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== design/rgb_to_yuv420_converter.sv =====
// RGB to YUV 4:2:0 converter, BT.601 fixed point, 2x2 chroma averaging.
// Depends on ryc_pkg and rgb_to_yuv420_converter_defines.svh.
//
// Usage:
//   Input stream s_axis: one RGB pixel per transfer in raster order,
//   tdata = {blue, green, red}. Output stream m_axis: one result per pixel,
//   tdata = {chroma_v, chroma_u, luma}, tuser = chroma_valid (set on the
//   bottom-right pixel of each 2x2 block, U/V zero otherwise), tlast = last
//   pixel of the frame. Frame size comes from the cfg port (index 0 width,
//   1 height; 0 acts as 1, above the maximum acts as the maximum); write it
//   only while the block is empty.
//   Each result is registered in stages 1, 2 and 3 before it reaches m_axis.
//   Throughput: one pixel per clock unless m_axis stalls. The line buffer holds
//   pair sums of the even row in a single-port-write, registered-read
//   memory, read at every input transfer and used on odd-row pairs, so no pixel waits on it.
//   Stall: each of the three stages loads when it is empty or its successor
//   loads; bubbles are squeezed out and s_axis_tready falls only when all
//   stages hold data and m_axis_tready is low.
//   Reset: counters and the left-pixel hold clear, sizes return to 256x256,
//   pipeline empties. The line buffer is not cleared and needs no sweep.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_to_yuv420_converter_defines.svh"

module rgb_to_yuv420_converter #(
	parameter int MAX_WIDTH  = ryc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = ryc_pkg::MAX_HEIGHT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration
	input  wire logic                          cfg_wr_en,
	input  wire logic [ryc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ryc_pkg::CFG_W-1:0]     cfg_data,
	// pixel input
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [23:0]                   s_axis_tdata,  // red, green, blue
	// result output
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [23:0]                        m_axis_tdata,  // luma, chroma_u, chroma_v
	output logic                               m_axis_tuser,  // chroma_valid
	output logic                               m_axis_tlast   // frame_last
);
	import ryc_pkg::*;

	localparam int XCNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YCNT_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WSZ_W  = (CFG_W > XCNT_W + 1) ? CFG_W : XCNT_W + 1;
	localparam int HSZ_W  = (CFG_W > YCNT_W + 1) ? CFG_W : YCNT_W + 1;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int LA_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// ---------------- configuration ----------------
	logic [CFG_W-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(SIZE_RESET);
			height_q <= CFG_W'(SIZE_RESET);
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [WSZ_W-1:0] w_eff, w_last;
	logic [HSZ_W-1:0] h_eff, h_last;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WSZ_W'(1);
		end else if (WSZ_W'(width_q) > WSZ_W'(MAX_WIDTH)) begin
			w_eff = WSZ_W'(MAX_WIDTH);
		end else begin
			w_eff = WSZ_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HSZ_W'(1);
		end else if (HSZ_W'(height_q) > HSZ_W'(MAX_HEIGHT)) begin
			h_eff = HSZ_W'(MAX_HEIGHT);
		end else begin
			h_eff = HSZ_W'(height_q);
		end
		w_last = w_eff - WSZ_W'(1);
		h_last = h_eff - HSZ_W'(1);
	end

	// ---------------- pipeline control ----------------
	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3, accept;

	assign en3 = !valid_s3 || m_axis_tready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_axis_tready = en1;
	assign accept = s_axis_tvalid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= accept;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	// ---------------- position and pairing ----------------
	logic [XCNT_W-1:0] x_q;
	logic [YCNT_W-1:0] y_q;
	pixel_t            left_q;
	pixel_t            pix;
	logic              last_col, last_row, odd_col, odd_row, have_pair;
	pair_sum_t         pair;
	logic [LA_W-1:0]   line_addr;

	assign pix       = pixel_t'(s_axis_tdata);
	assign last_col  = WSZ_W'(x_q) >= w_last;
	assign last_row  = HSZ_W'(y_q) >= h_last;
	assign odd_col   = x_q[0];
	assign odd_row   = y_q[0];
	assign have_pair = odd_col || last_col;
	assign line_addr = LA_W'(x_q >> 1);

	always_comb begin
		if (odd_col) begin
			pair.red   = PAIR_W'(left_q.red) + PAIR_W'(pix.red);
			pair.green = PAIR_W'(left_q.green) + PAIR_W'(pix.green);
			pair.blue  = PAIR_W'(left_q.blue) + PAIR_W'(pix.blue);
		end else begin
			// lone pixel in the last column: double it
			pair.red   = {pix.red, 1'b0};
			pair.green = {pix.green, 1'b0};
			pair.blue  = {pix.blue, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (!odd_col && !last_col) left_q <= pix;
			if (last_col) begin
				x_q <= '0;
				y_q <= last_row ? '0 : y_q + YCNT_W'(1);
			end else begin
				x_q <= x_q + XCNT_W'(1);
			end
		end
	end

	// ---------------- line buffer ----------------
	logic [LINE_W-1:0] line_mem [LINE_DEPTH];
	pair_sum_t         line_s1;

	always_ff @(posedge clk) begin
		if (accept && have_pair && !odd_row && !last_row) begin
			line_mem[line_addr] <= pair;
		end
		if (accept) begin
			line_s1 <= pair_sum_t'(line_mem[line_addr]);
		end
	end

	// ---------------- stage 1: input register ----------------
	pixel_t    pix_s1;
	pair_sum_t pair_s1;
	logic      cvalid_s1, dbl_s1, flast_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= pix;
			pair_s1   <= pair;
			cvalid_s1 <= have_pair && (odd_row || last_row);
			dbl_s1    <= !odd_row;   // even last row: double the pair
			flast_s1  <= last_col && last_row;
		end
	end

	// ---------------- stage 2: block sums and products ----------------
	logic [SUM_W-1:0]   sr, sg, sb;
	logic [LPROD_W-1:0] ly_r_s2, ly_g_s2, ly_b_s2;
	logic [CPROD_W-1:0] pu_r_s2, pu_g_s2, pu_b_s2, pv_r_s2, pv_g_s2, pv_b_s2;
	logic               cvalid_s2, flast_s2;

	always_comb begin
		if (dbl_s1) begin
			sr = {pair_s1.red, 1'b0};
			sg = {pair_s1.green, 1'b0};
			sb = {pair_s1.blue, 1'b0};
		end else begin
			sr = SUM_W'(line_s1.red) + SUM_W'(pair_s1.red);
			sg = SUM_W'(line_s1.green) + SUM_W'(pair_s1.green);
			sb = SUM_W'(line_s1.blue) + SUM_W'(pair_s1.blue);
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			ly_r_s2   <= LPROD_W'(pix_s1.red) * LPROD_W'(COEF_Y_R);
			ly_g_s2   <= LPROD_W'(pix_s1.green) * LPROD_W'(COEF_Y_G);
			ly_b_s2   <= LPROD_W'(pix_s1.blue) * LPROD_W'(COEF_Y_B);
			pu_r_s2   <= CPROD_W'(sr) * CPROD_W'(COEF_U_R);
			pu_g_s2   <= CPROD_W'(sg) * CPROD_W'(COEF_U_G);
			pu_b_s2   <= CPROD_W'(sb) * CPROD_W'(COEF_U_B);
			pv_r_s2   <= CPROD_W'(sr) * CPROD_W'(COEF_V_R);
			pv_g_s2   <= CPROD_W'(sg) * CPROD_W'(COEF_V_G);
			pv_b_s2   <= CPROD_W'(sb) * CPROD_W'(COEF_V_B);
			cvalid_s2 <= cvalid_s1;
			flast_s2  <= flast_s1;
		end
	end

	// ---------------- stage 3: sums, clamp, output register ----------------
	logic [LSUM_W-1:0]       lsum;
	logic signed [ACC_W-1:0] acc_u, acc_v;
	logic [PIX_W-1:0]        luma_s3, cu_s3, cv_s3;
	logic                    cvalid_s3, flast_s3;

	always_comb begin
		lsum  = LSUM_W'(ly_r_s2) + LSUM_W'(ly_g_s2) + LSUM_W'(ly_b_s2)
			+ LSUM_W'(LUMA_BIAS);
		acc_u = ACC_W'(pu_b_s2) - ACC_W'(pu_r_s2) - ACC_W'(pu_g_s2) + ACC_W'(UV_BIAS);
		acc_v = ACC_W'(pv_r_s2) - ACC_W'(pv_g_s2) - ACC_W'(pv_b_s2) + ACC_W'(UV_BIAS);
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			luma_s3   <= lsum[LUMA_SHIFT +: PIX_W];
			cu_s3     <= cvalid_s2 ? clip_uv(acc_u) : '0;
			cv_s3     <= cvalid_s2 ? clip_uv(acc_v) : '0;
			cvalid_s3 <= cvalid_s2;
			flast_s3  <= flast_s2;
		end
	end

	assign m_axis_tvalid = valid_s3;
	assign m_axis_tdata  = {cv_s3, cu_s3, luma_s3};
	assign m_axis_tuser  = cvalid_s3;
	assign m_axis_tlast  = flast_s3;

	// ---------------- assertions ----------------
	`RYC_ASSERT_ALWAYS(a_col_in_range, clk, arst_n, x_q <= XCNT_W'(MAX_WIDTH - 1))
	`RYC_ASSERT_NEXT(a_frame_wrap, clk, arst_n, accept && last_col && last_row,
		x_q == '0 && y_q == '0)
	`RYC_ASSERT_IMPLIES(a_no_chroma_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser,
		m_axis_tdata[23:8] == '0)

endmodule

`default_nettype wire

// ===== dv/ryc_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the RGB to YUV 4:2:0 converter: snoops the cfg port and both
// streams, predicts one result per pixel transfer and compares field by field.
// Depends on ryc_pkg for widths, the register enum and the pixel/pair types.

module ryc_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ryc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ryc_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [23:0]                   s_axis_tdata,  // red, green, blue
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [23:0]                   m_axis_tdata,  // luma, chroma_u, chroma_v
	input  wire logic                          m_axis_tuser,  // chroma_valid
	input  wire logic                          m_axis_tlast,  // frame_last
	output int                                 error_count,
	output int                                 pending_count,
	output int                                 results_checked,
	output int                                 chroma_checked
);
	import ryc_pkg::*;

	localparam int LINE_ENTRIES = (MAX_WIDTH_DEF + 1) / 2;
	localparam int MAX_REPORTS  = 60;

	typedef struct packed {
		logic [PIX_W-1:0] luma;
		logic [PIX_W-1:0] chroma_u;
		logic [PIX_W-1:0] chroma_v;
		logic             chroma_valid;
		logic             frame_last;
	} yuv_result_t;

	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	int unsigned      col_pos;
	int unsigned      row_pos;
	pixel_t           left_hold;
	pair_sum_t        pair_line [LINE_ENTRIES];
	yuv_result_t      expected_yuv_q [$];

	function automatic int unsigned frame_span(input logic [CFG_W-1:0] v, input int unsigned limit);
		if (v == '0) return 1;
		return (v > limit) ? limit : int'(v);
	endfunction

	// Round down after the bias, then clamp to a byte
	function automatic logic [PIX_W-1:0] uv_saturate(input int acc);
		int biased;
		biased = acc + (257 << 17);
		if (biased < 0) return '0;
		biased = biased >>> 18;
		return (biased > 255) ? 8'hff : PIX_W'(biased);
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: got %h, expected %h",
				results_checked, name, got, want));
	endtask

	task automatic convert_pixel(input pixel_t px);
		int unsigned w, h, idx;
		logic        at_last_col, at_last_row, have_pair;
		int          pr, pg, pb, sr, sg, sb;
		pair_sum_t   stored;
		yuv_result_t res;
		w = frame_span(width_reg, MAX_WIDTH_DEF);
		h = frame_span(height_reg, MAX_HEIGHT_DEF);
		at_last_col = (col_pos >= w - 1);
		at_last_row = (row_pos >= h - 1);
		idx = col_pos / 2;
		have_pair = 1'b0;
		pr = 0; pg = 0; pb = 0;
		sr = 0; sg = 0; sb = 0;
		res = '0;
		res.luma = PIX_W'((16839 * int'(px.red) + 33059 * int'(px.green)
			+ 6420 * int'(px.blue) + 32768 + (16 << 16)) >> 16);

		if (col_pos % 2 == 0) begin
			if (at_last_col) begin
				// odd last column: double the lone pixel
				pr = 2 * int'(px.red);
				pg = 2 * int'(px.green);
				pb = 2 * int'(px.blue);
				have_pair = 1'b1;
			end else begin
				left_hold = px;
			end
		end else begin
			pr = int'(left_hold.red) + int'(px.red);
			pg = int'(left_hold.green) + int'(px.green);
			pb = int'(left_hold.blue) + int'(px.blue);
			have_pair = 1'b1;
		end

		if (have_pair) begin
			if (row_pos % 2 == 0) begin
				if (at_last_row) begin
					// odd last row: double the horizontal pair
					sr = 2 * pr;
					sg = 2 * pg;
					sb = 2 * pb;
					res.chroma_valid = 1'b1;
				end else begin
					pair_line[idx].red   = PAIR_W'(pr);
					pair_line[idx].green = PAIR_W'(pg);
					pair_line[idx].blue  = PAIR_W'(pb);
				end
			end else begin
				stored = pair_line[idx];
				sr = int'(stored.red) + pr;
				sg = int'(stored.green) + pg;
				sb = int'(stored.blue) + pb;
				res.chroma_valid = 1'b1;
			end
		end

		if (res.chroma_valid) begin
			res.chroma_u = uv_saturate(-9719 * sr - 19081 * sg + 28800 * sb);
			res.chroma_v = uv_saturate(28800 * sr - 24116 * sg - 4684 * sb);
		end
		res.frame_last = at_last_col && at_last_row;

		if (at_last_col) begin
			col_pos = 0;
			row_pos = at_last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		expected_yuv_q.push_back(res);
	endtask

	task automatic compare_result();
		yuv_result_t want;
		if (expected_yuv_q.size() == 0) begin
			report_mismatch($sformatf("result with no pixel outstanding, tdata %h", m_axis_tdata));
		end else begin
			want = expected_yuv_q.pop_front();
			results_checked++;
			check_field("luma", m_axis_tdata[7:0], want.luma);
			check_field("chroma_u", m_axis_tdata[15:8], want.chroma_u);
			check_field("chroma_v", m_axis_tdata[23:16], want.chroma_v);
			check_field("chroma_valid", 8'(m_axis_tuser), 8'(want.chroma_valid));
			check_field("frame_last", 8'(m_axis_tlast), 8'(want.frame_last));
			if (want.chroma_valid) chroma_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = CFG_W'(SIZE_RESET);
			height_reg = CFG_W'(SIZE_RESET);
			col_pos = 0;
			row_pos = 0;
			left_hold = '0;
			expected_yuv_q.delete();
			error_count = 0;
			pending_count = 0;
			results_checked = 0;
			chroma_checked = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
				else if (cfg_index == REG_IMAGE_HEIGHT) height_reg = cfg_data;
			end
			// predict before comparing so a same-edge transfer can never be missed
			if (s_axis_tvalid && s_axis_tready) convert_pixel(pixel_t'(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) compare_result();
			pending_count = expected_yuv_q.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, cfg writes, bursty pixel
// stimulus and a stalling receiver; checking lives in ryc_checker.
// Depends on ryc_pkg, ryc_checker and rgb_to_yuv420_converter.

module tb_top;
	import ryc_pkg::*;

	localparam int CLK_PERIOD      = 20;
	localparam int ITEM_TARGET     = 1100;
	localparam int CYCLE_LIMIT     = 500000;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int HOLD_OFF_AFTER  = 40;
	localparam int DRAIN_SLACK     = 6;

	typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata;   // red, green, blue
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [23:0]          m_axis_tdata;   // luma, chroma_u, chroma_v
	logic                 m_axis_tuser;   // chroma_valid
	logic                 m_axis_tlast;   // frame_last

	int error_count;
	int pending_count;
	int results_checked;
	int chroma_checked;
	int pixels_sent = 0;
	int sizes_applied = 0;
	int burst_left = 0;
	int cycle_count = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	rgb_to_yuv420_converter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	ryc_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.error_count     (error_count),
		.pending_count   (pending_count),
		.results_checked (results_checked),
		.chroma_checked  (chroma_checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still outstanding",
				cycle_count, pending_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly random levels, with the rails picked often
	function automatic logic [PIX_W-1:0] rand_level();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic set_frame_size(input int unsigned w, input int unsigned h);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= CFG_W'(w);
		@(negedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= CFG_W'(h);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sizes_applied++;
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, g, r};
		do @(posedge clk); while (!s_axis_tready);
		pixels_sent++;
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_count == 0);
		repeat (DRAIN_SLACK) @(negedge clk);
		burst_left = 0;
	endtask

	// Receiver: random readiness, one long hold-off once the input is busy,
	// then spans of streaming, coin-flip, sparse and toggling readiness.
	initial begin
		rx_pattern_t pattern;
		int          span;
		m_axis_tready = 1'b0;
		while (pixels_sent < HOLD_OFF_AFTER) begin
			@(negedge clk);
			m_axis_tready <= 1'($urandom_range(0, 1));
		end
		@(negedge clk);
		m_axis_tready <= 1'b0;
		repeat (HOLD_OFF_CYCLES) @(negedge clk);
		forever begin
			pattern = rx_pattern_t'($urandom_range(0, 3));
			span = $urandom_range(16, 96);
			repeat (span) begin
				@(negedge clk);
				case (pattern)
					RX_STREAM: m_axis_tready <= 1'b1;
					RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) != 0);
					default:   m_axis_tready <= !m_axis_tready;
				endcase
			end
		end
	end

	initial begin
		int unsigned w_raw, h_raw, we, he, area, count, kind;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero size acts as 1x1: every pixel is a lone corner taken four times
		set_frame_size(0, 0);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		drain_results();

		// 3x3: full block, odd last column, odd last row and the corner
		set_frame_size(3, 3);
		send_pixel(8'hff, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hff, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hff);
		send_pixel(8'h55, 8'haa, 8'h55);
		send_pixel(8'haa, 8'h55, 8'haa);
		send_pixel(8'hff, 8'hff, 8'hff);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h80, 8'h7f, 8'h01);
		send_pixel(8'hfe, 8'h01, 8'hff);
		drain_results();

		// shrink mid-frame: position beyond the new edge becomes the frame end
		set_frame_size(4, 4);
		repeat (7) send_pixel(rand_level(), rand_level(), rand_level());
		drain_results();
		set_frame_size(2, 2);
		repeat (2) send_pixel(rand_level(), rand_level(), rand_level());
		drain_results();

		// widest frame fills every line entry, so later resizes read written data
		set_frame_size(511, 2);
		repeat (512) send_pixel(rand_level(), rand_level(), rand_level());
		drain_results();
		set_frame_size(0, 300);
		repeat (256) send_pixel(rand_level(), rand_level(), rand_level());
		drain_results();

		while (pixels_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				w_raw = $urandom_range(0, 1);
				h_raw = ($urandom_range(0, 3) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 40);
			end else if (kind == 1) begin
				w_raw = $urandom_range(13, 511);
				h_raw = $urandom_range(0, 2);
			end else begin
				w_raw = $urandom_range(1, 12);
				h_raw = $urandom_range(1, 12);
			end
			set_frame_size(w_raw, h_raw);
			we = (w_raw == 0) ? 1 : ((w_raw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_raw);
			he = (h_raw == 0) ? 1 : ((h_raw > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h_raw);
			area = we * he;
			// a third of the phases stop mid-frame, so the next size lands there
			if ($urandom_range(0, 2) == 0) count = $urandom_range(1, area + area / 2);
			else count = (area > 64) ? area : area * $urandom_range(1, 3);
			// stop at the item budget
			if (count > ITEM_TARGET - pixels_sent) count = ITEM_TARGET - pixels_sent;
			repeat (count) send_pixel(rand_level(), rand_level(), rand_level());
			drain_results();
		end

		repeat (DRAIN_SLACK) @(negedge clk);
		$display("Sent %0d pixels across %0d frame sizes: odd edges, lone corners, mid-frame resizes.",
			pixels_sent, sizes_applied);
		$display("Compared %0d results, %0d with a chroma sample, %0d mismatches.",
			results_checked, chroma_checked, error_count);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
